### hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, widths and the line-element operator shared by the binary curvature
// smoothing block and its channel interfaces.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int WIN_W = 25;
	localparam int POS_W = 12;
	localparam int CFG_W = 13;
	localparam int NB_W  = 9;

	localparam int ROWS_RESET = 480;
	localparam int COLS_RESET = 640;

	typedef logic [WIN_W-1:0] window_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CFG_W-1:0] side_t;
	typedef logic [NB_W-1:0]  nbhd_t;

	typedef enum logic [0:0] {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} cfg_idx_t;

	// 3x3 neighbourhood, bit 3*r+c, centre at bit 4.
	// lo set: OR along each line, AND across lines; clear: the dual.
	// Positions with ok low drop out of their line.
	function automatic logic line_comb(input nbhd_t v, input nbhd_t ok, input logic lo);
		nbhd_t      d_or;
		nbhd_t      d_and;
		logic [3:0] l_or;
		logic [3:0] l_and;
		logic       res;
		d_or     = v & ok;
		d_and    = v | ~ok;
		l_or[0]  = d_or[3] | d_or[4] | d_or[5];
		l_or[1]  = d_or[1] | d_or[4] | d_or[7];
		l_or[2]  = d_or[0] | d_or[4] | d_or[8];
		l_or[3]  = d_or[2] | d_or[4] | d_or[6];
		l_and[0] = d_and[3] & d_and[4] & d_and[5];
		l_and[1] = d_and[1] & d_and[4] & d_and[7];
		l_and[2] = d_and[0] & d_and[4] & d_and[8];
		l_and[3] = d_and[2] & d_and[4] & d_and[6];
		if (lo) begin
			res = &l_or;
		end else begin
			res = |l_and;
		end
		return res;
	endfunction

endpackage

### hw/rtl/bcs_if.sv
// ----------------------------------------------------------------------------
// bcs channel interfaces
// Valid/ready channels for pixel beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface bcs_pix_if;
	import bcs_pkg::*;

	logic    valid;
	logic    ready;
	window_t window;
	pos_t    row;
	pos_t    col;
	logic    frame_end;

	modport source (output valid, output window, output row, output col,
		output frame_end, input ready);
	modport sink (input valid, input window, input row, input col,
		input frame_end, output ready);
endinterface

interface bcs_res_if;
	logic valid;
	logic ready;
	logic smoothed;
	logic mode_used;

	modport source (output valid, output smoothed, output mode_used, input ready);
	modport sink (input valid, input smoothed, input mode_used, output ready);
endinterface

interface bcs_cfg_if;
	import bcs_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	side_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/binary_curvature_smoothing_top.sv
// ----------------------------------------------------------------------------
// binary_curvature_smoothing_top
// Morphological sup-inf / inf-sup curvature smoothing of a binary level-set
// mask, one pixel per beat from its 5x5 neighbourhood.
// ----------------------------------------------------------------------------
// Takes one pixel beat per cycle and returns one result beat per pixel, in
// order. Each result passes the registers of stages one, two and three and
// shows on the output from stage three. The bounds of the window rows and
// columns are checked on the way into stage one. Stage two forms the nine
// intermediate points with the first line pass. Stage three applies the second
// line pass into the output register. Back-pressure stalls the pipeline in
// place. The pass order starts as sup-inf first after reset and swaps after
// each pixel flagged frame_end.
// Image sizes above MAX_SIDE act as MAX_SIDE; write them only while idle.
module binary_curvature_smoothing_top #(
	parameter int MAX_SIDE = 4096
) (
	input logic      clk,
	input logic      arst_n,
	bcs_pix_if.sink   pix,
	bcs_res_if.source res,
	bcs_cfg_if.sink   cfg
);
	import bcs_pkg::*;

	localparam int    SideCapI = (MAX_SIDE > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_SIDE;
	localparam side_t SIDE_CAP = CFG_W'(SideCapI);
	localparam side_t ROWS_RST = CFG_W'((ROWS_RESET > SideCapI) ? SideCapI : ROWS_RESET);
	localparam side_t COLS_RST = CFG_W'((COLS_RESET > SideCapI) ? SideCapI : COLS_RESET);
	localparam int    SUM_W    = POS_W + 2;

	side_t rows_q;
	side_t cols_q;
	side_t cfg_lim;
	logic  mode_q;

	logic  en1;
	logic  en2;
	logic  en3;
	logic  pix_acc;

	logic       v_s1;
	window_t    win_s1;
	logic [4:0] rok_s1;
	logic [4:0] cok_s1;
	logic       mode_s1;

	logic  v_s2;
	nbhd_t mid_s2;
	nbhd_t ok3_s2;
	logic  mode_s2;

	logic v_s3;
	logic smooth_s3;
	logic mode_s3;

	logic [4:0] rok_d;
	logic [4:0] cok_d;
	nbhd_t      mid_d;
	nbhd_t      ok3_d;
	logic       smooth_d;

	assign en3     = !v_s3 || res.ready;
	assign en2     = !v_s2 || en3;
	assign en1     = !v_s1 || en2;
	assign pix.ready = en1;
	assign pix_acc = pix.valid && en1;

	assign cfg.ready = 1'b1;
	assign cfg_lim   = (cfg.data > SIDE_CAP) ? SIDE_CAP : cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_ROWS: rows_q <= cfg_lim;
				REG_IMAGE_COLS: cols_q <= cfg_lim;
				default: ;
			endcase
		end
	end

	// toggle pass order after the last pixel of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (pix_acc && pix.frame_end) begin
			mode_q <= !mode_q;
		end
	end

	always_comb begin
		logic [SUM_W-1:0] rsum;
		logic [SUM_W-1:0] csum;
		for (int i = 0; i < 5; i++) begin
			rsum     = {2'b00, pix.row} + SUM_W'(i) - SUM_W'(2);
			csum     = {2'b00, pix.col} + SUM_W'(i) - SUM_W'(2);
			rok_d[i] = rsum < {1'b0, rows_q};
			cok_d[i] = csum < {1'b0, cols_q};
		end
	end

	always_comb begin
		nbhd_t sub_v;
		nbhd_t sub_ok;
		for (int ci = 0; ci < 3; ci++) begin
			for (int cj = 0; cj < 3; cj++) begin
				for (int a = 0; a < 3; a++) begin
					for (int b = 0; b < 3; b++) begin
						sub_v[a*3+b]  = win_s1[5*(ci+a)+(cj+b)];
						sub_ok[a*3+b] = rok_s1[ci+a] & cok_s1[cj+b];
					end
				end
				mid_d[ci*3+cj] = line_comb(sub_v, sub_ok, mode_s1);
				ok3_d[ci*3+cj] = rok_s1[ci+1] & cok_s1[cj+1];
			end
		end
	end

	assign smooth_d = line_comb(mid_s2, ok3_s2, !mode_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pix.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			win_s1  <= pix.window;
			rok_s1  <= rok_d;
			cok_s1  <= cok_d;
			mode_s1 <= mode_q;
		end
		if (en2) begin
			mid_s2  <= mid_d;
			ok3_s2  <= ok3_d;
			mode_s2 <= mode_s1;
		end
		if (en3) begin
			smooth_s3 <= smooth_d;
			mode_s3   <= mode_s2;
		end
	end

	assign res.valid     = v_s3;
	assign res.smoothed  = smooth_s3;
	assign res.mode_used = mode_s3;

`ifndef NO_ASSERTIONS
	a_mode_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && pix.frame_end) |=> (mode_q != $past(mode_q)))
		else $error("pass order did not swap after frame end");

	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_acc && pix.frame_end) |=> $stable(mode_q))
		else $error("pass order changed without frame end");

	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && !res.ready) |=> (v_s2 && v_s3))
		else $error("pipeline dropped a beat while stalled");
`endif

endmodule
